// ===== rtl/core/mhpq_pkg.sv =====
// Package for the binary min-heap priority queue.
// Holds sizes, status codes and the controller state type; no dependencies.
package mhpq_pkg;

    // Heap size and derived widths
    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int DATA_W   = 32;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Transaction action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_RM_ROOT,
        ST_RM_LAST,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_PUT,
        ST_FIN
    } t_state;

endpackage

// ===== rtl/core/mhpq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; read-first when both ports hit the same address.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Storage array and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/min_heap_priority_queue.sv =====
// Top level of the binary min-heap priority queue: controller and output register.
// Depends on mhpq_pkg and mhpq_ram (heap store).
//
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_action, i_value
// output    out        o_valid / i_stall   o_removed_value, o_status, o_entry_count
//
// Insert sifts up, reading and comparing one parent at a time. Remove reads the root and
// the last entry, then sifts down, reading both children of each level before comparing.
// Removing the last entry reads only the root; a dropped or empty request goes to completion.
// The single read port of the heap store allows one entry read per cycle.
// Reset (synchronous, active low) empties the heap; the store itself is not cleared.
// A new transaction is taken while a finished result waits; completion holds on i_stall.
module min_heap_priority_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_action,
    input  logic signed [31:0]          i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_removed_value,
    output logic [1:0]                  o_status,
    output logic [7:0]                  o_entry_count
);
    import mhpq_pkg::*;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [ADDR_W-1:0]         r_hole, n_hole;
    logic signed [DATA_W-1:0]  r_val, n_val;
    logic signed [DATA_W-1:0]  r_child, n_child;
    logic [ADDR_W-1:0]         r_child_idx, n_child_idx;
    logic                      r_has_right, n_has_right;
    logic signed [DATA_W-1:0]  r_res_removed, n_res_removed;
    logic [1:0]                r_res_status, n_res_status;
    logic                      r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0]  r_out_removed, n_out_removed;
    logic [1:0]                r_out_status, n_out_status;
    logic [7:0]                r_out_count, n_out_count;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [DATA_W-1:0]         ram_wdata;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [DATA_W-1:0]         ram_rdata;
    logic signed [DATA_W-1:0]  rd_val;

    logic                      in_acc;
    logic                      out_free;
    logic [ADDR_W-1:0]         parent_idx;
    logic [CHILD_W-1:0]        left_idx;
    logic [CHILD_W-1:0]        right_idx;
    logic                      take_right;
    logic signed [DATA_W-1:0]  pick_val;
    logic [ADDR_W-1:0]         pick_idx;

    // Heap store
    mhpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_val = $signed(ram_rdata);

    // Handshake
    assign o_stall  = (r_state != ST_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // Heap index arithmetic
    assign parent_idx = ADDR_W'((r_hole - ADDR_W'(1)) >> 1);
    assign left_idx   = {1'b0, r_hole, 1'b0} + CHILD_W'(1);
    assign right_idx  = left_idx + CHILD_W'(1);

    // Smaller child, left on a tie
    assign take_right = r_has_right && (rd_val < r_child);
    assign pick_val   = take_right ? rd_val : r_child;
    assign pick_idx   = take_right ? ADDR_W'(right_idx) : r_child_idx;

    // State register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_hole        <= n_hole;
        r_val         <= n_val;
        r_child       <= n_child;
        r_child_idx   <= n_child_idx;
        r_has_right   <= n_has_right;
        r_res_removed <= n_res_removed;
        r_res_status  <= n_res_status;
        r_out_removed <= n_out_removed;
        r_out_status  <= n_out_status;
        r_out_count   <= n_out_count;
    end

    // Next state, store access and result
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_hole        = r_hole;
        n_val         = r_val;
        n_child       = r_child;
        n_child_idx   = r_child_idx;
        n_has_right   = r_has_right;
        n_res_removed = r_res_removed;
        n_res_status  = r_res_status;
        n_out_valid   = r_out_valid && i_stall;
        n_out_removed = r_out_removed;
        n_out_status  = r_out_status;
        n_out_count   = r_out_count;
        ram_we        = 1'b0;
        ram_waddr     = r_hole;
        ram_wdata     = r_val;
        ram_raddr     = '0;

        case (r_state)
            ST_IDLE: begin
                // root read is issued here so a remove sees it next cycle
                ram_raddr = '0;
                if (in_acc) begin
                    n_res_removed = '0;
                    n_res_status  = STAT_OK;
                    if (i_action == ACT_INSERT) begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_res_status = STAT_FULL;
                            n_state      = ST_FIN;
                        end else begin
                            n_val   = i_value;
                            n_hole  = ADDR_W'(r_count);
                            n_count = r_count + CNT_W'(1);
                            n_state = (r_count == '0) ? ST_PUT : ST_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_removed = '1;
                            n_res_status  = STAT_EMPTY;
                            n_state       = ST_FIN;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                            n_state = ST_RM_ROOT;
                        end
                    end
                end
            end
            ST_UP_RD: begin
                ram_raddr = parent_idx;
                n_state   = ST_UP_CMP;
            end
            ST_UP_CMP: begin
                // parent strictly greater: move it down into the hole
                if (r_val < rd_val) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    n_hole    = parent_idx;
                    n_state   = (parent_idx == '0) ? ST_PUT : ST_UP_RD;
                end else begin
                    n_state = ST_PUT;
                end
            end
            ST_RM_ROOT: begin
                n_res_removed = rd_val;
                ram_raddr     = ADDR_W'(r_count);
                n_state       = (r_count == '0) ? ST_FIN : ST_RM_LAST;
            end
            ST_RM_LAST: begin
                n_val   = rd_val;
                n_hole  = '0;
                n_state = ST_DN_RDL;
            end
            ST_DN_RDL: begin
                if (left_idx >= CHILD_W'(r_count)) begin
                    n_state = ST_PUT;
                end else begin
                    ram_raddr = ADDR_W'(left_idx);
                    n_state   = ST_DN_RDR;
                end
            end
            ST_DN_RDR: begin
                n_child     = rd_val;
                n_child_idx = ADDR_W'(left_idx);
                n_has_right = (right_idx < CHILD_W'(r_count));
                ram_raddr   = ADDR_W'(right_idx);
                n_state     = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                // smaller child strictly below the moving entry: pull it up
                if (pick_val < r_val) begin
                    ram_we    = 1'b1;
                    ram_wdata = pick_val;
                    n_hole    = pick_idx;
                    n_state   = ST_DN_RDL;
                end else begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                ram_we  = 1'b1;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_removed = r_res_removed;
                    n_out_status  = r_res_status;
                    n_out_count   = 8'(r_count);
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_removed_value = r_out_removed;
    assign o_status        = r_out_status;
    assign o_entry_count   = r_out_count;

`ifndef SYNTHESIS
    // Count never exceeds the heap size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Count moves by at most one per transaction, only on acceptance
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_count))
        else $error("entry count changed without a transaction");

    // Store is never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !ram_we)
        else $error("heap store written while idle");

    // An empty result always carries -1 and a zero count
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_EMPTY) |-> (o_removed_value == -32'sd1
            && o_entry_count == 8'd0))
        else $error("empty result with wrong payload");

    // A result is loaded only on leaving the completion state
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("completion did not produce a result");
`endif

endmodule
